// File: rtl/core/tett_pkg.sv
package tett_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int TIME_BITS   = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_ADD     = 3'd1;
    localparam logic [2:0] ACT_NEXT    = 3'd2;
    localparam logic [2:0] ACT_RESTART = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    typedef struct packed {
        logic [2:0]           action;
        logic [15:0]          delta_time;
        logic                 defeated;
        logic [TIME_BITS-1:0] entry_time;
        logic                 entry_enabled;
        logic [TIME_BITS-1:0] start_time;
    } tett_cmd_t;

    typedef struct packed {
        logic [3:0] entry_index;
        logic       fired;
        logic       last;
    } tett_result_t;

endpackage

// File: rtl/core/timed_event_trigger_table.sv
// Command-driven trigger table. A transaction is taken when start is high and busy is low;
// add, restart and clear finish in that cycle. A tick walks the N stored entries one per
// cycle through a single time comparator, and with auto-advance set and defeated high it
// then searches for the next eligible entry one entry per cycle; fire next uses only that
// search. The finish state flushes the final result. A result is held until the next
// entry fires or the transaction finishes, so at most one leaves per cycle on
// result_strobe; results cannot be held off, and the last one of a transaction carries
// last.
module timed_event_trigger_table
    import tett_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  tett_cmd_t    cmd,
    output logic         busy,
    output logic         result_strobe,
    output tett_result_t result,
    input  logic         cfg_we,
    input  logic         cfg_wdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TICK   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]             state_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic                   pass_reg;
    logic                   defeated_reg;
    logic                   auto_advance_reg;

    logic [TIME_BITS-1:0]   times_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] enable_bits_reg;
    logic [MAX_ENTRIES-1:0] fired_bits_reg;
    logic [CNT_W-1:0]       entry_count_reg;
    logic [TIME_BITS-1:0]   running_time_reg;
    logic                   last_valid_reg;
    logic [IDX_W-1:0]       last_index_reg;

    logic                   pend_valid_reg;
    logic [IDX_W-1:0]       pend_index_reg;
    logic                   pend_fired_reg;

    logic                   accept;
    logic [TIME_BITS:0]     time_sum;
    logic [IDX_W-1:0]       cur_idx;
    logic                   in_range;
    logic                   cur_eligible;
    logic                   time_reached;
    logic [MAX_ENTRIES-1:0] count_mask;
    logic                   any_eligible;
    logic [CNT_W-1:0]       search_start;
    logic                   fire_now;

    assign accept   = start && !busy;
    assign busy     = (state_reg != ST_IDLE);
    assign time_sum = {1'b0, running_time_reg} + {{(TIME_BITS + 1 - 16){1'b0}}, cmd.delta_time};

    assign cur_idx      = idx_reg[IDX_W-1:0];
    assign in_range     = (idx_reg < entry_count_reg);
    assign cur_eligible = enable_bits_reg[cur_idx] && !fired_bits_reg[cur_idx];
    // The one shared comparator of the tick scan.
    assign time_reached = (running_time_reg >= times_mem[cur_idx]);

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            count_mask[i] = (CNT_W'(i) < entry_count_reg);
        end
    end

    assign any_eligible = |(enable_bits_reg & ~fired_bits_reg & count_mask);
    assign search_start = last_valid_reg ? (CNT_W'(last_index_reg) + CNT_W'(1)) : '0;

    assign fire_now = in_range && cur_eligible &&
                      ((state_reg == ST_TICK && time_reached) || state_reg == ST_SEARCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_advance_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            auto_advance_reg <= cfg_wdata;
        end
    end

    // Entry payload needs no reset: entries at or past the count never affect a result.
    always_ff @(posedge clk)
    begin
        if (accept && cmd.action == ACT_ADD && entry_count_reg < CNT_W'(MAX_ENTRIES))
        begin
            times_mem[entry_count_reg[IDX_W-1:0]]       <= cmd.entry_time;
            enable_bits_reg[entry_count_reg[IDX_W-1:0]] <= cmd.entry_enabled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            pass_reg         <= 1'b0;
            defeated_reg     <= 1'b0;
            fired_bits_reg   <= '0;
            entry_count_reg  <= '0;
            running_time_reg <= '0;
            last_valid_reg   <= 1'b0;
            last_index_reg   <= '0;
            pend_valid_reg   <= 1'b0;
            pend_index_reg   <= '0;
            pend_fired_reg   <= 1'b0;
            result_strobe    <= 1'b0;
            result           <= '0;
        end
        else
        begin
            result_strobe <= pend_valid_reg && (fire_now || state_reg == ST_FINISH);

            // A newly fired entry pushes the previous pending result out as not last.
            if (fire_now)
            begin
                fired_bits_reg[cur_idx] <= 1'b1;
                last_valid_reg          <= 1'b1;
                last_index_reg          <= cur_idx;
                pend_valid_reg          <= 1'b1;
                pend_index_reg          <= cur_idx;
                pend_fired_reg          <= 1'b1;
                if (pend_valid_reg)
                begin
                    result <= '{entry_index: pend_index_reg, fired: pend_fired_reg,
                                last: 1'b0};
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        defeated_reg <= cmd.defeated;
                        case (cmd.action)
                            ACT_TICK:
                            begin
                                running_time_reg <= time_sum[TIME_BITS] ?
                                                    {TIME_BITS{1'b1}} : time_sum[TIME_BITS-1:0];
                                idx_reg          <= '0;
                                state_reg        <= ST_TICK;
                            end
                            ACT_ADD:
                            begin
                                if (entry_count_reg < CNT_W'(MAX_ENTRIES))
                                begin
                                    fired_bits_reg[entry_count_reg[IDX_W-1:0]] <= 1'b0;
                                    entry_count_reg <= entry_count_reg + CNT_W'(1);
                                end
                            end
                            ACT_NEXT:
                            begin
                                idx_reg   <= search_start;
                                pass_reg  <= 1'b0;
                                state_reg <= ST_SEARCH;
                            end
                            ACT_RESTART:
                            begin
                                running_time_reg <= cmd.start_time;
                                fired_bits_reg   <= '0;
                                last_valid_reg   <= 1'b0;
                                last_index_reg   <= '0;
                            end
                            ACT_CLEAR:
                            begin
                                entry_count_reg  <= '0;
                                running_time_reg <= '0;
                                fired_bits_reg   <= '0;
                                last_valid_reg   <= 1'b0;
                                last_index_reg   <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_TICK:
                begin
                    if (in_range)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (auto_advance_reg && defeated_reg && any_eligible)
                    begin
                        idx_reg   <= search_start;
                        pass_reg  <= 1'b0;
                        state_reg <= ST_SEARCH;
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_SEARCH:
                begin
                    if (fire_now)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else if (in_range)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else if (!pass_reg)
                    begin
                        idx_reg  <= '0;
                        pass_reg <= 1'b1;
                    end
                    else
                    begin
                        // Nothing eligible: only a fire-next transaction gets here.
                        pend_valid_reg <= 1'b1;
                        pend_index_reg <= '0;
                        pend_fired_reg <= 1'b0;
                        state_reg      <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (pend_valid_reg)
                    begin
                        result         <= '{entry_index: pend_index_reg, fired: pend_fired_reg,
                                            last: 1'b1};
                        pend_valid_reg <= 1'b0;
                    end
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_last_then_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.last |=> !result_strobe)
        else $error("result followed the final result of a transaction too soon");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !pend_valid_reg)
        else $error("pending result left behind when idle");

    a_not_fired_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.fired |-> result.last)
        else $error("empty fire-next result not marked last");

    a_fired_within_count: assert property (@(posedge clk) disable iff (!rst_n)
        (fired_bits_reg & ~count_mask) == '0)
        else $error("fired bit set beyond the entry count");

endmodule

// File: test/tett_fire_monitor.sv
module tett_fire_monitor
    import tett_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         busy,
    input  tett_cmd_t    cmd,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         result_strobe,
    input  tett_result_t result,
    output int           mismatches,
    output int           outstanding,
    output int           results_seen
);

    localparam int RESULT_CAP = 16;

    logic [TIME_BITS-1:0]   trig_time [MAX_ENTRIES];
    logic                   trig_en   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] done_mask;
    int                     n_entries;
    logic [TIME_BITS-1:0]   clock_ms;
    logic                   prev_valid;
    int                     prev_idx;
    logic                   auto_adv;
    int                     n_new;
    tett_result_t           firings_due [$];

    function automatic bit can_fire(input int i);
        return trig_en[i] && !done_mask[i];
    endfunction

    task automatic queue_firing(input int i, input logic hit);
        tett_result_t r;
        r.entry_index = i[3:0];
        r.fired       = hit;
        r.last        = 1'b0;
        if (n_new < RESULT_CAP)
        begin
            firings_due = {firings_due, r};
            n_new++;
        end
    endtask

    task automatic mark_fired(input int i);
        done_mask[i] = 1'b1;
        prev_valid   = 1'b1;
        prev_idx     = i;
        queue_firing(i, 1'b1);
    endtask

    // Search onward from the entry that fired last, wrapping around once.
    task automatic fire_following(output bit found);
        int first;
        found = 1'b0;
        first = prev_valid ? prev_idx + 1 : 0;
        for (int lap = 0; lap < 2 && !found; lap++)
        begin
            for (int i = first; i < n_entries && !found; i++)
            begin
                if (can_fire(i))
                begin
                    mark_fired(i);
                    found = 1'b1;
                end
            end
            first = 0;
        end
    endtask

    task automatic predict_firings(input tett_cmd_t c);
        logic [TIME_BITS:0] sum;
        bit                 any_left;
        bit                 found;
        n_new = 0;
        case (c.action)
            ACT_TICK:
            begin
                sum      = {1'b0, clock_ms} + (TIME_BITS + 1)'(c.delta_time);
                clock_ms = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                for (int i = 0; i < n_entries; i++)
                begin
                    if (can_fire(i) && clock_ms >= trig_time[i])
                        mark_fired(i);
                end
                if (auto_adv && c.defeated)
                begin
                    any_left = 1'b0;
                    for (int i = 0; i < n_entries; i++)
                    begin
                        if (can_fire(i))
                            any_left = 1'b1;
                    end
                    if (any_left)
                        fire_following(found);
                end
            end
            ACT_ADD:
            begin
                if (n_entries < MAX_ENTRIES)
                begin
                    trig_time[n_entries] = c.entry_time;
                    trig_en[n_entries]   = c.entry_enabled;
                    done_mask[n_entries] = 1'b0;
                    n_entries++;
                end
            end
            ACT_NEXT:
            begin
                fire_following(found);
                if (!found)
                    queue_firing(0, 1'b0);
            end
            ACT_RESTART:
            begin
                clock_ms   = c.start_time;
                done_mask  = '0;
                prev_valid = 1'b0;
                prev_idx   = 0;
            end
            ACT_CLEAR:
            begin
                n_entries  = 0;
                clock_ms   = '0;
                done_mask  = '0;
                prev_valid = 1'b0;
                prev_idx   = 0;
            end
            default:
            begin
            end
        endcase
        if (n_new > 0)
            firings_due[firings_due.size() - 1].last = 1'b1;
    endtask

    task automatic check_result(input tett_result_t got);
        tett_result_t want;
        results_seen++;
        if (firings_due.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected result: index %0d fired %0b last %0b",
                         got.entry_index, got.fired, got.last);
            mismatches++;
        end
        else
        begin
            want = firings_due.pop_front();
            if (got.entry_index !== want.entry_index || got.fired !== want.fired ||
                got.last !== want.last)
            begin
                if (mismatches < 10)
                    $display({"result mismatch: expected index %0d fired %0b last %0b, ",
                              "got index %0d fired %0b last %0b"},
                             want.entry_index, want.fired, want.last,
                             got.entry_index, got.fired, got.last);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_mask    = '0;
            n_entries    = 0;
            clock_ms     = '0;
            prev_valid   = 1'b0;
            prev_idx     = 0;
            auto_adv     = 1'b0;
            mismatches   = 0;
            results_seen = 0;
            firings_due.delete();
            outstanding  = 0;
        end
        else
        begin
            // Results of earlier transactions are retired before a new one is predicted.
            if (result_strobe)
                check_result(result);
            if (cfg_we)
                auto_adv = cfg_wdata;
            if (start && !busy)
                predict_firings(cmd);
            outstanding = firings_due.size();
        end
    end

endmodule

// File: test/tb_timed_event_trigger_table.sv
module tb_timed_event_trigger_table;
    import tett_pkg::*;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         start     = 1'b0;
    tett_cmd_t    cmd       = '0;
    logic         cfg_we    = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         busy;
    logic         result_strobe;
    tett_result_t result;

    int mismatches;
    int outstanding;
    int results_seen;
    int cmds_sent;
    int settings_used;
    int burst_left;

    timed_event_trigger_table uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    tett_fire_monitor fire_mon (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_strobe (result_strobe),
        .result        (result),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

    // Every field starts random so that fields an action ignores still toggle.
    function automatic tett_cmd_t noise_cmd();
        tett_cmd_t c;
        c.action        = 3'($urandom_range(0, 7));
        c.delta_time    = 16'($urandom);
        c.defeated      = 1'($urandom_range(0, 1));
        c.entry_time    = $urandom;
        c.entry_enabled = 1'($urandom_range(0, 1));
        c.start_time    = $urandom;
        return c;
    endfunction

    function automatic tett_cmd_t op_cmd(input logic [2:0] a);
        tett_cmd_t c;
        c = noise_cmd();
        c.action = a;
        return c;
    endfunction

    function automatic tett_cmd_t tick_cmd(input logic [15:0] d, input logic dft);
        tett_cmd_t c;
        c = op_cmd(ACT_TICK);
        c.delta_time = d;
        c.defeated   = dft;
        return c;
    endfunction

    function automatic tett_cmd_t add_cmd(input logic [31:0] t, input logic en);
        tett_cmd_t c;
        c = op_cmd(ACT_ADD);
        c.entry_time    = t;
        c.entry_enabled = en;
        return c;
    endfunction

    function automatic tett_cmd_t restart_cmd(input logic [31:0] t);
        tett_cmd_t c;
        c = op_cmd(ACT_RESTART);
        c.start_time = t;
        return c;
    endfunction

    function automatic logic [15:0] pick_delta();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 400));
        endcase
    endfunction

    function automatic logic [31:0] pick_entry_time();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    function automatic logic [31:0] pick_start_time();
        case ($urandom_range(0, 7))
            0: return 32'hFFFF_FF00 + $urandom_range(0, 255);
            1: return $urandom;
            default: return $urandom_range(0, 1500);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction
    // was taken, with start still high.
    task automatic send_cmd(input tett_cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        if (c.action <= ACT_CLEAR)
            cmds_sent++;
        @(negedge clk);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic paced_send(input tett_cmd_t c);
        send_cmd(c);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            hold_off($urandom_range(1, 40));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 25)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Wait for every predicted result, then give a command with no result time to finish.
    task automatic settle();
        int waited;
        start <= 1'b0;
        waited = 0;
        while ((outstanding != 0 || busy) && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (60) @(negedge clk);
    endtask

    task automatic write_auto(input logic v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // A round is mostly well formed: optionally empty or restart the table, load some
    // entries, then run ticks and fire-next requests over them, with a little noise.
    task automatic random_round();
        int sel;
        int n_add;
        int n_ops;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            paced_send(op_cmd(ACT_CLEAR));
        else if (sel < 6)
            paced_send(restart_cmd(pick_start_time()));
        n_add = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 4);
        repeat (n_add)
            paced_send(add_cmd(pick_entry_time(), $urandom_range(0, 3) != 0));
        n_ops = $urandom_range(2, 8);
        repeat (n_ops)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                paced_send(tick_cmd(pick_delta(), 1'($urandom_range(0, 1))));
            else if (sel < 8)
                paced_send(op_cmd(ACT_NEXT));
            else if (sel == 8)
                paced_send(noise_cmd());
            else
                paced_send(op_cmd(3'($urandom_range(5, 7))));
        end
    endtask

    initial
    begin
        int target;
        cmds_sent     = 0;
        settings_used = 0;
        burst_left    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_auto(1'b0);
        send_cmd(op_cmd(ACT_NEXT));
        send_cmd(tick_cmd(16'hFFFF, 1'b1));
        send_cmd(restart_cmd(32'h0000_0000));
        send_cmd(add_cmd(32'h0000_0000, 1'b1));
        send_cmd(add_cmd(32'hFFFF_FFFF, 1'b1));
        send_cmd(add_cmd(32'd100, 1'b0));
        send_cmd(add_cmd(32'd50, 1'b1));
        send_cmd(add_cmd(32'd200, 1'b1));
        send_cmd(tick_cmd(16'd0, 1'b0));
        send_cmd(tick_cmd(16'd60, 1'b0));
        send_cmd(op_cmd(ACT_NEXT));
        // This search runs off the end of the table and wraps to the front.
        send_cmd(op_cmd(ACT_NEXT));
        send_cmd(op_cmd(ACT_NEXT));
        // The running time saturates here, so every enabled entry fires in this tick.
        send_cmd(restart_cmd(32'hFFFF_FFF0));
        send_cmd(tick_cmd(16'hFFFF, 1'b0));
        send_cmd(op_cmd(3'd5));
        send_cmd(op_cmd(3'd6));
        send_cmd(op_cmd(3'd7));

        write_auto(1'b1);
        send_cmd(restart_cmd(32'h0000_0000));
        send_cmd(tick_cmd(16'd10, 1'b1));
        send_cmd(tick_cmd(16'd0, 1'b1));
        send_cmd(tick_cmd(16'd0, 1'b0));
        send_cmd(op_cmd(ACT_CLEAR));
        send_cmd(tick_cmd(16'd5, 1'b1));
        send_cmd(op_cmd(ACT_NEXT));

        target = cmds_sent;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_auto((phase < 2) ? 1'(phase) : 1'($urandom_range(0, 1)));
            target += 18;
            while (cmds_sent < target)
                random_round();
        end

        settle();
        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        $display("Run covered %0d commands under %0d auto-advance settings,",
                 cmds_sent, settings_used);
        $display("with %0d results compared.", results_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
